// File: src/cam_pkg.sv
// ----------------------------------------------------------------------------
// cam_pkg
// Shared codes, widths and result word layout of the addressing mode unit.
// ----------------------------------------------------------------------------
package cam_pkg;

  localparam int IN_TDATA_W  = 136;
  localparam int OUT_TDATA_W = 120;
  localparam int IN_TUSER_W  = 1;
  localparam int OUT_TUSER_W = 2;

  // operation codes (input tuser)
  localparam logic OP_START   = 1'b0;
  localparam logic OP_POINTER = 1'b1;

  // addressing modes
  localparam logic [3:0] MODE_DP  = 4'd0;
  localparam logic [3:0] MODE_DPX = 4'd1;
  localparam logic [3:0] MODE_DPY = 4'd2;
  localparam logic [3:0] MODE_IDP = 4'd3;
  localparam logic [3:0] MODE_IDX = 4'd4;
  localparam logic [3:0] MODE_IDY = 4'd5;
  localparam logic [3:0] MODE_IDL = 4'd6;
  localparam logic [3:0] MODE_ILY = 4'd7;
  localparam logic [3:0] MODE_SR  = 4'd8;
  localparam logic [3:0] MODE_ISY = 4'd9;
  localparam logic [3:0] MODE_ABS = 4'd10;
  localparam logic [3:0] MODE_ABX = 4'd11;
  localparam logic [3:0] MODE_ABY = 4'd12;
  localparam logic [3:0] MODE_ABL = 4'd13;
  localparam logic [3:0] MODE_ALX = 4'd14;
  localparam logic [3:0] MODE_IAX = 4'd15;

  // result kinds (output tuser)
  localparam logic [1:0] KIND_FINAL   = 2'd0;
  localparam logic [1:0] KIND_FETCH   = 2'd1;
  localparam logic [1:0] KIND_IGNORED = 2'd2;

  localparam logic [1:0] PTR_WIDTH_2 = 2'd2;
  localparam logic [1:0] PTR_WIDTH_3 = 2'd3;

  typedef struct packed {
    logic [1:0]  result_kind;
    logic [23:0] effective_low;
    logic [23:0] effective_high;
    logic [23:0] pointer_low_addr;
    logic [23:0] pointer_high_addr;
    logic [15:0] pointer_bank_addr;
    logic [1:0]  pointer_width;
    logic [1:0]  extra_cycles;
    logic [1:0]  operand_bytes;
  } result_t;

endpackage

// File: src/cpu_addressing_mode_unit.sv
// ----------------------------------------------------------------------------
// cpu_addressing_mode_unit
// Effective address generation for a 16-bit 6502-family CPU, sixteen modes.
//
// channel | dir | tdata                        | tuser
// s_axis  | in  | start / pointer word, 136 b  | operation
// m_axis  | out | address result word, 120 b   | result_kind
//
// One word in, one word out; a new word is taken every cycle while s_axis_tready is high.
// The result is registered in the output stage and shown on m_axis_tvalid.
// A two-entry output stage (result register plus skid) takes a word while
// a finished result is stalled; s_axis_tready drops only with both full.
// rst is synchronous and clears the pending pointer state and the stage.
// ----------------------------------------------------------------------------
module cpu_addressing_mode_unit (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // mode, operand, write_flag, direct_page, data_bank, program_bank,
  // stack_pointer, index_x, index_y, index_8bit, pointer_data, zero pad
  input  logic [cam_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
  // operation
  input  logic [cam_pkg::IN_TUSER_W-1:0]      s_axis_tuser,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // effective_low, effective_high, pointer_low_addr, pointer_high_addr,
  // pointer_bank_addr, pointer_width, extra_cycles, operand_bytes, zero pad
  output logic [cam_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
  // result_kind
  output logic [cam_pkg::OUT_TUSER_W-1:0]     m_axis_tuser
);
  import cam_pkg::*;

  // input fields
  logic        operation;
  logic [3:0]  mode;
  logic [23:0] operand;
  logic        write_flag;
  logic [15:0] direct_page;
  logic [7:0]  data_bank;
  logic [7:0]  program_bank;
  logic [15:0] stack_pointer;
  logic [15:0] index_x;
  logic [15:0] index_y;
  logic        index_8bit;
  logic [23:0] pointer_data;

  assign operation     = s_axis_tuser[0];
  assign mode          = s_axis_tdata[3:0];
  assign operand       = s_axis_tdata[27:4];
  assign write_flag    = s_axis_tdata[28];
  assign direct_page   = s_axis_tdata[44:29];
  assign data_bank     = s_axis_tdata[52:45];
  assign program_bank  = s_axis_tdata[60:53];
  assign stack_pointer = s_axis_tdata[76:61];
  assign index_x       = s_axis_tdata[92:77];
  assign index_y       = s_axis_tdata[108:93];
  assign index_8bit    = s_axis_tdata[109];
  assign pointer_data  = s_axis_tdata[133:110];

  // held state of a pending indirect mode
  logic        pending;
  logic [3:0]  held_mode;
  logic [7:0]  held_data_bank;
  logic [15:0] held_index_y;
  logic        held_index_8bit;
  logic        held_write_flag;
  logic        held_dp_penalty;

  // output stage
  result_t out_word;
  result_t skid_word;
  logic    out_valid;
  logic    skid_valid;

  logic    in_acc;
  logic    out_pop;
  result_t res;
  logic    is_indirect;

  // start-side terms
  logic [7:0]  a8;
  logic [15:0] a16;
  logic [15:0] dp_idx;
  logic [15:0] dp_base;
  logic [15:0] sr_base;
  logic [15:0] abs_idx;
  logic [16:0] abs_sum;
  logic [23:0] abs_lo;
  logic [23:0] long_lo;
  logic [15:0] iax_off;
  logic        abs_pen;
  logic        dp_pen;

  // pointer-side terms
  logic [15:0] p16;
  logic [16:0] fin_sum;
  logic [23:0] fin_lo;
  logic        fin_pen;

  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign out_pop       = out_valid && m_axis_tready;
  assign s_axis_tready = !skid_valid;

  assign a8      = operand[7:0];
  assign a16     = operand[15:0];
  assign dp_idx  = (mode == MODE_DPX || mode == MODE_IDX) ? index_x :
                   (mode == MODE_DPY) ? index_y : 16'h0000;
  assign dp_base = 16'(direct_page + {8'h00, a8} + dp_idx);
  assign sr_base = 16'(stack_pointer + {8'h00, a8});
  assign abs_idx = (mode == MODE_ABX) ? index_x :
                   (mode == MODE_ABY) ? index_y : 16'h0000;
  assign abs_sum = {1'b0, a16} + {1'b0, abs_idx};
  assign abs_lo  = 24'({data_bank, 16'h0000} + {7'h00, abs_sum});
  assign long_lo = operand + ((mode == MODE_ALX) ? {8'h00, index_x} : 24'h000000);
  assign iax_off = 16'(a16 + index_x);
  assign abs_pen = write_flag && (!index_8bit || (abs_sum[16:8] != {1'b0, a16[15:8]}));
  assign dp_pen  = (direct_page[7:0] != 8'h00);

  assign p16     = pointer_data[15:0];
  assign fin_sum = {1'b0, p16} + {1'b0, held_index_y};
  assign fin_pen = held_write_flag &&
                   (!held_index_8bit || (fin_sum[16:8] != {1'b0, p16[15:8]}));

  always_comb begin
    case (held_mode)
      MODE_IDP, MODE_IDX: fin_lo = {held_data_bank, 16'h0000} + {8'h00, p16};
      MODE_IDY, MODE_ISY: fin_lo = 24'({held_data_bank, 16'h0000} + {7'h00, fin_sum});
      MODE_IDL:           fin_lo = pointer_data;
      MODE_ILY:           fin_lo = pointer_data + {8'h00, held_index_y};
      default:            fin_lo = {8'h00, p16};
    endcase
  end

  always_comb begin
    res                   = '0;
    res.pointer_width     = PTR_WIDTH_2;
    is_indirect           = 1'b0;
    if (operation == OP_POINTER) begin
      if (!pending) begin
        res.result_kind = KIND_IGNORED;
      end else begin
        res.result_kind   = KIND_FINAL;
        res.effective_low = fin_lo;
        case (held_mode)
          MODE_IDP, MODE_IDX, MODE_IDL, MODE_ILY: begin
            res.effective_high = fin_lo + 24'd1;
            res.extra_cycles   = {1'b0, held_dp_penalty};
          end
          MODE_IDY: begin
            res.effective_high = fin_lo + 24'd1;
            res.extra_cycles   = 2'({1'b0, held_dp_penalty} + {1'b0, fin_pen});
          end
          MODE_ISY: begin
            res.effective_high = fin_lo + 24'd1;
          end
          default: begin
            res.effective_high = 24'h000000;
          end
        endcase
      end
    end else begin
      res.result_kind = KIND_FINAL;
      case (mode)
        MODE_DP, MODE_DPX, MODE_DPY: begin
          res.effective_low  = {8'h00, dp_base};
          res.effective_high = {8'h00, 16'(dp_base + 16'd1)};
          res.extra_cycles   = {1'b0, dp_pen};
          res.operand_bytes  = 2'd1;
        end
        MODE_SR: begin
          res.effective_low  = {8'h00, sr_base};
          res.effective_high = {8'h00, 16'(sr_base + 16'd1)};
          res.operand_bytes  = 2'd1;
        end
        MODE_ABS, MODE_ABX, MODE_ABY: begin
          res.effective_low  = abs_lo;
          res.effective_high = abs_lo + 24'd1;
          res.extra_cycles   = {1'b0, (mode != MODE_ABS) && abs_pen};
          res.operand_bytes  = 2'd2;
        end
        MODE_ABL, MODE_ALX: begin
          res.effective_low  = long_lo;
          res.effective_high = long_lo + 24'd1;
          res.operand_bytes  = 2'd3;
        end
        MODE_IAX: begin
          is_indirect           = 1'b1;
          res.result_kind       = KIND_FETCH;
          res.pointer_low_addr  = {program_bank, iax_off};
          res.pointer_high_addr = {program_bank, 16'(iax_off + 16'd1)};
          res.operand_bytes     = 2'd2;
        end
        MODE_ISY: begin
          is_indirect           = 1'b1;
          res.result_kind       = KIND_FETCH;
          res.pointer_low_addr  = {8'h00, sr_base};
          res.pointer_high_addr = {8'h00, 16'(sr_base + 16'd1)};
          res.operand_bytes     = 2'd1;
        end
        default: begin
          is_indirect           = 1'b1;
          res.result_kind       = KIND_FETCH;
          res.pointer_low_addr  = {8'h00, dp_base};
          res.pointer_high_addr = {8'h00, 16'(dp_base + 16'd1)};
          if (mode == MODE_IDL || mode == MODE_ILY) begin
            res.pointer_bank_addr = 16'(dp_base + 16'd2);
            res.pointer_width     = PTR_WIDTH_3;
          end
          res.operand_bytes     = 2'd1;
        end
      endcase
    end
  end

  // pending pointer state
  always_ff @(posedge clk) begin
    if (rst) begin
      pending         <= 1'b0;
      held_mode       <= 4'h0;
      held_data_bank  <= 8'h00;
      held_index_y    <= 16'h0000;
      held_index_8bit <= 1'b0;
      held_write_flag <= 1'b0;
      held_dp_penalty <= 1'b0;
    end else if (in_acc) begin
      if (operation == OP_POINTER) begin
        pending <= 1'b0;
      end else begin
        pending <= is_indirect;
        if (is_indirect) begin
          held_mode       <= mode;
          held_data_bank  <= data_bank;
          held_index_y    <= index_y;
          held_index_8bit <= index_8bit;
          held_write_flag <= write_flag;
          held_dp_penalty <= dp_pen && (mode != MODE_IAX) && (mode != MODE_ISY);
        end
      end
    end
  end

  // result register and skid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (out_pop) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end
    end else if (in_acc) begin
      if (!out_valid || out_pop) begin
        out_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end else if (out_pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (out_pop) begin
        out_word <= skid_word;
      end
    end else if (in_acc) begin
      if (!out_valid || out_pop) begin
        out_word <= res;
      end else begin
        skid_word <= res;
      end
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tuser  = out_word.result_kind;
  assign m_axis_tdata  = {2'b00,
                          out_word.operand_bytes,
                          out_word.extra_cycles,
                          out_word.pointer_width,
                          out_word.pointer_bank_addr,
                          out_word.pointer_high_addr,
                          out_word.pointer_low_addr,
                          out_word.effective_high,
                          out_word.effective_low};

  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid word held without a result word");

  a_start_sets_pending: assert property (@(posedge clk) disable iff (rst)
    (in_acc && operation == OP_START && is_indirect) |=> pending)
    else $error("indirect start did not leave a pending pointer");

  a_pointer_clears: assert property (@(posedge clk) disable iff (rst)
    (in_acc && operation == OP_POINTER) |=> !pending)
    else $error("pointer word left state pending");

  a_stall_fills_skid: assert property (@(posedge clk) disable iff (rst)
    (in_acc && out_valid && !m_axis_tready) |=> skid_valid)
    else $error("word taken under stall was not parked");

  a_fetch_only_from_start: assert property (@(posedge clk) disable iff (rst)
    (in_acc && operation == OP_POINTER && !skid_valid && (!out_valid || out_pop))
      |=> m_axis_tuser != KIND_FETCH)
    else $error("pointer word produced a fetch request");

endmodule
